>>> rtl/core/dsfb_pkg.sv
// Shared constants, codes and types of the distance sensor filter bank.
package dsfb_pkg;

   localparam int CHANNELS   = 4;
   // The window length must be a power of two; the mean is a right shift.
   localparam int WINDOW     = 8;
   localparam int WIN_SHIFT  = $clog2(WINDOW);
   localparam int POS_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   localparam int SAMPLE_W   = 12;
   localparam int OFFSET_W   = 8;
   localparam int BAND_W     = 12;
   localparam int VAL_W      = 13;
   localparam int MODE_W     = 2;
   localparam int SUM_W      = VAL_W + WIN_SHIFT;

   // First-order low-pass in Q15: y = (FB*y_prev + FF*(x + x_prev)) >> 15.
   localparam int LP_FB      = 31752;
   localparam int LP_FF      = 508;
   localparam int LP_SHIFT   = 15;
   localparam int LP_ACC_W   = VAL_W + LP_SHIFT;
   localparam int LP_RESET   = 750;
   localparam int BAND_MARGIN = 10;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 13;
   localparam int REQ_W      = CHANNELS * SAMPLE_W;
   localparam int RSP_FIELDS_W = CHANNELS * VAL_W + 3;
   localparam int RSP_W      = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [MODE_W-1:0] MODE_AVG    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LP_AVG = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LP     = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] REG_FILTER_MODE = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_NOISE_LOW   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_NOISE_HIGH  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_DETECT_THR  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_OFFSET_CH0  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_OFFSET_CH1  = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_OFFSET_CH2  = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_OFFSET_CH3  = 3'd7;

   typedef struct packed {
      logic              ld_clamp;
      logic              ld_lp;
      logic              ld_avg;
      logic              lp_en;
      logic              avg_en;
      logic [POS_W-1:0]  pos;
      logic [BAND_W-1:0] band_low;
      logic [BAND_W-1:0] band_high;
   } lane_ctrl_type;

   typedef logic [CHANNELS-1:0][VAL_W-1:0] lane_vals_type;

endpackage

>>> rtl/core/dsfb_lane.sv
// One channel lane: offset and band clamp, Q15 low-pass, moving average.
module dsfb_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  dsfb_pkg::lane_ctrl_type       ctrl,
   input  logic [dsfb_pkg::SAMPLE_W-1:0] sample,
   input  logic [dsfb_pkg::OFFSET_W-1:0] offset,
   output logic [dsfb_pkg::VAL_W-1:0]    filt
);
   import dsfb_pkg::*;

   logic [VAL_W-1:0]    raw;
   logic [VAL_W-1:0]    low_ext;
   logic [VAL_W-1:0]    high_ext;
   logic [VAL_W-1:0]    x_in;
   logic [VAL_W-1:0]    x_ff;

   logic [LP_ACC_W-1:0] lp_acc;
   logic [VAL_W-1:0]    lp_y_in;
   logic [VAL_W-1:0]    lp_y_ff;
   logic [VAL_W-1:0]    lp_x_ff;
   logic [VAL_W-1:0]    s2_in;
   logic [VAL_W-1:0]    s2_ff;

   logic [VAL_W-1:0]    win_ff [WINDOW];
   logic [VAL_W-1:0]    win_old;
   logic [SUM_W-1:0]    sum_in;
   logic [SUM_W-1:0]    sum_ff;
   logic [VAL_W-1:0]    s3_in;
   logic [VAL_W-1:0]    s3_ff;

   // Clamp stage. A value exactly at the low edge counts as below the band.
   always_comb begin
      raw      = VAL_W'(sample) + VAL_W'(offset);
      low_ext  = VAL_W'(ctrl.band_low);
      high_ext = VAL_W'(ctrl.band_high);
      if (raw > low_ext && raw < high_ext) begin
         x_in = raw;
      end else if (raw >= high_ext) begin
         x_in = high_ext + VAL_W'(BAND_MARGIN);
      end else if (low_ext >= VAL_W'(BAND_MARGIN)) begin
         x_in = low_ext - VAL_W'(BAND_MARGIN);
      end else begin
         x_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld_clamp) begin
         x_ff <= x_in;
      end
   end

   // Low-pass stage. The weights sum to one, so the result fits VAL_W bits.
   always_comb begin
      lp_acc  = LP_ACC_W'(LP_FB) * LP_ACC_W'(lp_y_ff)
              + LP_ACC_W'(LP_FF) * (LP_ACC_W'(x_ff) + LP_ACC_W'(lp_x_ff));
      lp_y_in = lp_acc[LP_ACC_W-1:LP_SHIFT];
      s2_in   = ctrl.lp_en ? lp_y_in : x_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lp_y_ff <= VAL_W'(LP_RESET);
         lp_x_ff <= VAL_W'(LP_RESET);
      end else if (ctrl.ld_lp && ctrl.lp_en) begin
         lp_y_ff <= lp_y_in;
         lp_x_ff <= x_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld_lp) begin
         s2_ff <= s2_in;
      end
   end

   // Moving average stage: running sum minus the sample that leaves the window.
   always_comb begin
      win_old = win_ff[ctrl.pos];
      sum_in  = sum_ff - SUM_W'(win_old) + SUM_W'(s2_ff);
      s3_in   = ctrl.avg_en ? sum_in[WIN_SHIFT +: VAL_W] : s2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         for (int i = 0; i < WINDOW; i++) begin
            win_ff[i] <= '0;
         end
      end else if (ctrl.ld_avg && ctrl.avg_en) begin
         sum_ff           <= sum_in;
         win_ff[ctrl.pos] <= s2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld_avg) begin
         s3_ff <= s3_in;
      end
   end

   assign filt = s3_ff;

endmodule

>>> rtl/core/dsfb_merge.sv
// Merge stage: front mean of channels 0 and 3, detect flags, result register.
module dsfb_merge (
   input  logic                            clock,
   input  logic                            ld,
   input  dsfb_pkg::lane_vals_type         lane_vals,
   input  logic [dsfb_pkg::VAL_W-1:0]      threshold,
   output logic [dsfb_pkg::RSP_W-1:0]      rsp_data
);
   import dsfb_pkg::*;

   logic [VAL_W:0]   front_sum;
   logic [VAL_W-1:0] front;
   logic             det_front;
   logic             det_1;
   logic             det_2;
   logic [RSP_W-1:0] data_in;
   logic [RSP_W-1:0] data_ff;

   always_comb begin
      front_sum = (VAL_W + 1)'(lane_vals[0]) + (VAL_W + 1)'(lane_vals[3]);
      front     = front_sum[VAL_W:1];
      det_front = front > threshold;
      det_1     = lane_vals[1] > threshold;
      det_2     = lane_vals[2] > threshold;
      data_in   = RSP_W'({det_2, det_1, det_front,
                          lane_vals[3], lane_vals[2], lane_vals[1], front});
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         data_ff <= data_in;
      end
   end

   assign rsp_data = data_ff;

endmodule

>>> rtl/core/distance_sensor_filter_bank_top.sv
// Top level of the four-channel distance sensor filter bank.
//
//   Group  Dir  Ports                       Beat
//   req    in   req_tvalid/tready/tdata     one scan of four raw samples
//   rsp    out  rsp_tvalid/tready/tdata     filtered values and detect flags
//   csr    in   csr_we/csr_addr/csr_wdata   one register write, no wait
//
// A scan passes four register stages (clamp, low-pass, average, merge) to the
// result; one scan is taken each cycle until a stalled result fills every stage.
// The low-pass and running-sum feedback loops each close within one stage.
// Reset is synchronous and restores registers, filter state and the window.
// Each stage holds its beat while the one after it is full and stalled, so a
// stalled result still lets up to three more scans enter behind it.
module distance_sensor_filter_bank_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // sample_0, sample_1, sample_2, sample_3
   input  logic [dsfb_pkg::REQ_W-1:0]        req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // front_value, filtered_1, filtered_2, filtered_3, detect_front,
   // detect_1, detect_2, zero pad
   output logic [dsfb_pkg::RSP_W-1:0]        rsp_tdata,
   input  logic                              csr_we,
   input  logic [dsfb_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [dsfb_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dsfb_pkg::*;

   logic [MODE_W-1:0]   mode_ff,  mode_in;
   logic [BAND_W-1:0]   low_ff,   low_in;
   logic [BAND_W-1:0]   high_ff,  high_in;
   logic [VAL_W-1:0]    thr_ff,   thr_in;
   logic [OFFSET_W-1:0] offset_ff [CHANNELS];
   logic [OFFSET_W-1:0] offset_in [CHANNELS];

   logic                lp_en;
   logic                avg_en;
   logic [POS_W-1:0]    pos_ff,   pos_in;

   logic                v1_ff, v2_ff, v3_ff, v4_ff;
   logic                v1_in, v2_in, v3_in, v4_in;
   logic                rdy1, rdy2, rdy3, rdy4;
   logic                ld1, ld2, ld3, ld4;

   lane_ctrl_type       lane_ctrl;
   lane_vals_type       lane_vals;

   // Configuration registers.
   always_comb begin
      mode_in = mode_ff;
      low_in  = low_ff;
      high_in = high_ff;
      thr_in  = thr_ff;
      for (int i = 0; i < CHANNELS; i++) begin
         offset_in[i] = offset_ff[i];
      end
      if (csr_we) begin
         case (csr_addr)
            REG_FILTER_MODE: mode_in      = csr_wdata[MODE_W-1:0];
            REG_NOISE_LOW:   low_in       = csr_wdata[BAND_W-1:0];
            REG_NOISE_HIGH:  high_in      = csr_wdata[BAND_W-1:0];
            REG_DETECT_THR:  thr_in       = csr_wdata[VAL_W-1:0];
            REG_OFFSET_CH0:  offset_in[0] = csr_wdata[OFFSET_W-1:0];
            REG_OFFSET_CH1:  offset_in[1] = csr_wdata[OFFSET_W-1:0];
            REG_OFFSET_CH2:  offset_in[2] = csr_wdata[OFFSET_W-1:0];
            REG_OFFSET_CH3:  offset_in[3] = csr_wdata[OFFSET_W-1:0];
            default:         mode_in      = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_AVG;
         low_ff       <= BAND_W'(100);
         high_ff      <= BAND_W'(3000);
         thr_ff       <= VAL_W'(1000);
         offset_ff[0] <= OFFSET_W'(74);
         offset_ff[1] <= OFFSET_W'(50);
         offset_ff[2] <= '0;
         offset_ff[3] <= '0;
      end else begin
         mode_ff <= mode_in;
         low_ff  <= low_in;
         high_ff <= high_in;
         thr_ff  <= thr_in;
         for (int i = 0; i < CHANNELS; i++) begin
            offset_ff[i] <= offset_in[i];
         end
      end
   end

   // The spare mode code behaves as the plain moving average.
   always_comb begin
      case (mode_ff)
         MODE_LP_AVG: begin
            lp_en  = 1'b1;
            avg_en = 1'b1;
         end
         MODE_LP: begin
            lp_en  = 1'b1;
            avg_en = 1'b0;
         end
         default: begin
            lp_en  = 1'b0;
            avg_en = 1'b1;
         end
      endcase
   end

   // Pipeline flow: a stage takes a beat when it is empty or its beat moves on.
   always_comb begin
      rdy4  = !v4_ff || rsp_tready;
      rdy3  = !v3_ff || rdy4;
      rdy2  = !v2_ff || rdy3;
      rdy1  = !v1_ff || rdy2;
      ld1   = req_tvalid && rdy1;
      ld2   = v1_ff && rdy2;
      ld3   = v2_ff && rdy3;
      ld4   = v3_ff && rdy4;
      v1_in = ld1 || (v1_ff && !rdy2);
      v2_in = ld2 || (v2_ff && !rdy3);
      v3_in = ld3 || (v3_ff && !rdy4);
      v4_in = ld4 || (v4_ff && !rsp_tready);
      if (ld3 && avg_en) begin
         pos_in = (pos_ff == POS_W'(WINDOW - 1)) ? '0 : pos_ff + 1'b1;
      end else begin
         pos_in = pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         pos_ff <= '0;
      end else begin
         v1_ff  <= v1_in;
         v2_ff  <= v2_in;
         v3_ff  <= v3_in;
         v4_ff  <= v4_in;
         pos_ff <= pos_in;
      end
   end

   always_comb begin
      lane_ctrl.ld_clamp  = ld1;
      lane_ctrl.ld_lp     = ld2;
      lane_ctrl.ld_avg    = ld3;
      lane_ctrl.lp_en     = lp_en;
      lane_ctrl.avg_en    = avg_en;
      lane_ctrl.pos       = pos_ff;
      lane_ctrl.band_low  = low_ff;
      lane_ctrl.band_high = high_ff;
   end

   for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
      dsfb_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (lane_ctrl),
         .sample (req_tdata[ch*SAMPLE_W +: SAMPLE_W]),
         .offset (offset_ff[ch]),
         .filt   (lane_vals[ch])
      );
   end

   dsfb_merge u_merge (
      .clock     (clock),
      .ld        (ld4),
      .lane_vals (lane_vals),
      .threshold (thr_ff),
      .rsp_data  (rsp_tdata)
   );

   assign req_tready = rdy1;
   assign rsp_tvalid = v4_ff;

`ifndef SYNTHESIS
   // Input is refused only when every stage is full and the result is stalled.
   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (v1_ff && v2_ff && v3_ff && v4_ff && !rsp_tready))
      else $error("input blocked with a bubble in the pipeline");

   // A new result can only come from a beat held in the average stage.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(v3_ff))
      else $error("result appeared without a beat in the average stage");

   // Low-pass only mode leaves the window position alone.
   a_pos_hold: assert property (@(posedge clock) disable iff (reset)
      !avg_en |=> $stable(pos_ff))
      else $error("window position moved while averaging was off");
`endif

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the four-channel distance sensor filter bank.
module testbench;
   import dsfb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WIN_LEN     = 8;
   localparam int unsigned LP_FEEDBACK = 31752;
   localparam int unsigned LP_FEEDFWD  = 508;
   localparam int unsigned LP_START    = 750;
   localparam int unsigned BAND_PAD    = 10;
   localparam int unsigned RANDOM_SCANS = 650;
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   typedef logic [3:0][11:0] scan_type;

   typedef struct packed {
      logic [12:0] front_value;
      logic [12:0] filtered_1;
      logic [12:0] filtered_2;
      logic [12:0] filtered_3;
      logic        detect_front;
      logic        detect_1;
      logic        detect_2;
   } bank_result_type;

   typedef enum logic {STEP_SCAN, STEP_WRITE} step_kind_type;
   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_style_type;

   typedef struct packed {
      step_kind_type   kind;
      logic [2:0]      reg_idx;
      logic [12:0]     reg_val;
      logic [11:0]     s0;
      logic [11:0]     s1;
      logic [11:0]     s2;
      logic [11:0]     s3;
      logic            pinned;
      bank_result_type want;
   } step_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Shadow copy of the block's registers and filter state.
   logic [1:0]  cfg_mode;
   logic [11:0] cfg_low;
   logic [11:0] cfg_high;
   logic [12:0] cfg_thr;
   logic [7:0]  cfg_offset [4];
   logic [12:0] win_samples [4][WIN_LEN];
   logic [18:0] win_sums [4];
   int unsigned win_ptr;
   logic [12:0] lp_out_hist [4];
   logic [12:0] lp_in_hist [4];

   bank_result_type pending_results [$];
   int           mismatches = 0;
   int           burst_left = 0;
   int           gap_left = 0;
   int           phase_level [4];
   rx_style_type rx_style = RX_OPEN;
   int           rx_left = 0;

   // Only the first two rows start from a known state simple enough to type in.
   step_type directed_steps [36] = '{
      '{STEP_SCAN, REG_FILTER_MODE, 13'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1,
        '{13'd11, 13'd11, 13'd11, 13'd11, 1'b0, 1'b0, 1'b0}},
      '{STEP_SCAN, REG_FILTER_MODE, 13'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1,
        '{13'd387, 13'd387, 13'd387, 13'd387, 1'b0, 1'b0, 1'b0}},
      '{STEP_SCAN, REG_FILTER_MODE, 13'd0, 12'd26, 12'd50, 12'd100, 12'd101, 1'b0, '0},
      '{STEP_SCAN, REG_FILTER_MODE, 13'd0, 12'd2926, 12'd2950, 12'd3000, 12'd2999, 1'b0, '0},
      '{STEP_SCAN, REG_FILTER_MODE, 13'd0, 12'd1234, 12'd2048, 12'd777, 12'd3333, 1'b0, '0},
      '{STEP_WRITE, REG_FILTER_MODE, 13'(MODE_LP_AVG), 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{STEP_SCAN, REG_FILTER_MODE, 13'd0, 12'd500, 12'd1500, 12'd2500, 12'd3500, 1'b0, '0},
      '{STEP_SCAN, REG_FILTER_MODE, 13'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 1'b0, '0},
      '{STEP_WRITE, REG_FILTER_MODE, 13'(MODE_LP), 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{STEP_SCAN, REG_FILTER_MODE, 13'd0, 12'd3000, 12'd100, 12'd2000, 12'd1000, 1'b0, '0},
      '{STEP_SCAN, REG_FILTER_MODE, 13'd0, 12'd0, 12'd4095, 12'd0, 12'd4095, 1'b0, '0},
      '{STEP_WRITE, REG_FILTER_MODE, 13'(MODE_SPARE), 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{STEP_SCAN, REG_FILTER_MODE, 13'd0, 12'd1111, 12'd2222, 12'd3333, 12'd444, 1'b0, '0},
      '{STEP_WRITE, REG_NOISE_LOW, 13'd5, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{STEP_WRITE, REG_NOISE_HIGH, 13'd4095, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{STEP_WRITE, REG_DETECT_THR, 13'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{STEP_WRITE, REG_OFFSET_CH0, 13'd255, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{STEP_WRITE, REG_OFFSET_CH1, 13'd255, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{STEP_WRITE, REG_OFFSET_CH2, 13'd255, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{STEP_WRITE, REG_OFFSET_CH3, 13'd255, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{STEP_WRITE, REG_FILTER_MODE, 13'(MODE_AVG), 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{STEP_SCAN, REG_FILTER_MODE, 13'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{STEP_SCAN, REG_FILTER_MODE, 13'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0, '0},
      '{STEP_WRITE, REG_NOISE_LOW, 13'd4095, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{STEP_WRITE, REG_NOISE_HIGH, 13'd10, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{STEP_WRITE, REG_DETECT_THR, 13'd8191, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{STEP_WRITE, REG_OFFSET_CH0, 13'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{STEP_WRITE, REG_OFFSET_CH1, 13'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{STEP_WRITE, REG_OFFSET_CH2, 13'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{STEP_WRITE, REG_OFFSET_CH3, 13'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{STEP_SCAN, REG_FILTER_MODE, 13'd0, 12'd0, 12'd5, 12'd10, 12'd4095, 1'b0, '0},
      '{STEP_SCAN, REG_FILTER_MODE, 13'd0, 12'd9, 12'd11, 12'd3, 12'd2048, 1'b0, '0},
      '{STEP_WRITE, REG_FILTER_MODE, 13'(MODE_LP_AVG), 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{STEP_SCAN, REG_FILTER_MODE, 13'd0, 12'd4095, 12'd4095, 12'd0, 12'd0, 1'b0, '0},
      '{STEP_WRITE, REG_FILTER_MODE, 13'(MODE_LP), 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
      '{STEP_SCAN, REG_FILTER_MODE, 13'd0, 12'd1, 12'd2, 12'd3, 12'd4, 1'b0, '0}
   };

   distance_sensor_filter_bank_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   task automatic load_reset_state();
      cfg_mode = MODE_AVG;
      cfg_low = 12'd100;
      cfg_high = 12'd3000;
      cfg_thr = 13'd1000;
      cfg_offset = '{8'd74, 8'd50, 8'd0, 8'd0};
      win_ptr = 0;
      for (int ch = 0; ch < 4; ch++) begin
         win_sums[ch] = '0;
         lp_out_hist[ch] = 13'(LP_START);
         lp_in_hist[ch] = 13'(LP_START);
         for (int k = 0; k < WIN_LEN; k++) win_samples[ch][k] = '0;
      end
   endtask

   function automatic int unsigned band_limit(int unsigned v);
      if (v > cfg_low && v < cfg_high) return v;
      if (v >= cfg_high) return cfg_high + BAND_PAD;
      return (cfg_low >= BAND_PAD) ? cfg_low - BAND_PAD : 0;
   endfunction

   // Advances the shadow filter state by one scan and returns the result beat.
   function automatic bank_result_type filter_scan(scan_type s);
      bank_result_type r;
      logic [1:0]   mode;
      int unsigned  x;
      int unsigned  acc;
      int unsigned  front;
      int unsigned  filt [4];
      mode = (cfg_mode == MODE_SPARE) ? MODE_AVG : cfg_mode;
      for (int ch = 0; ch < 4; ch++) begin
         x = band_limit(int'(s[ch]) + int'(cfg_offset[ch]));
         if (mode != MODE_AVG) begin
            acc = LP_FEEDBACK * lp_out_hist[ch] + LP_FEEDFWD * x
                + LP_FEEDFWD * lp_in_hist[ch];
            lp_out_hist[ch] = 13'(acc >> 15);
            lp_in_hist[ch] = 13'(x);
            x = 32'(lp_out_hist[ch]);
         end
         if (mode != MODE_LP) begin
            win_sums[ch] = 19'(win_sums[ch] - win_samples[ch][win_ptr] + x);
            win_samples[ch][win_ptr] = 13'(x);
            filt[ch] = win_sums[ch] / WIN_LEN;
         end else begin
            filt[ch] = x;
         end
      end
      if (mode != MODE_LP) win_ptr = (win_ptr + 1) % WIN_LEN;
      front = (filt[0] + filt[3]) / 2;
      r.front_value = 13'(front);
      r.filtered_1 = 13'(filt[1]);
      r.filtered_2 = 13'(filt[2]);
      r.filtered_3 = 13'(filt[3]);
      r.detect_front = front > cfg_thr;
      r.detect_1 = filt[1] > cfg_thr;
      r.detect_2 = filt[2] > cfg_thr;
      return r;
   endfunction

   function automatic logic [11:0] pick_sample(int ch);
      int v;
      case ($urandom_range(0, 6))
         0: v = int'(cfg_low) - int'(cfg_offset[ch]) + int'($urandom_range(0, 6)) - 3;
         1: v = int'(cfg_high) - int'(cfg_offset[ch]) + int'($urandom_range(0, 6)) - 3;
         2, 3: v = phase_level[ch] + int'($urandom_range(0, 80)) - 40;
         default: v = int'($urandom_range(0, 4095));
      endcase
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v[11:0];
   endfunction

   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_addr <= idx;
      csr_wdata <= val;
      csr_we <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_FILTER_MODE: cfg_mode = val[1:0];
         REG_NOISE_LOW:   cfg_low = val[11:0];
         REG_NOISE_HIGH:  cfg_high = val[11:0];
         REG_DETECT_THR:  cfg_thr = val;
         default:         cfg_offset[idx - REG_OFFSET_CH0] = val[7:0];
      endcase
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Sends one scan in the current burst; a pinned row overrides the prediction.
   task automatic send_scan(scan_type s, bit pinned, bank_result_type want);
      bank_result_type predicted;
      csr_we <= 1'b0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
      end
      if (gap_left > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap_left) @(posedge clock);
         gap_left = 0;
      end
      req_tvalid <= 1'b1;
      req_tdata <= s;
      do @(posedge clock); while (!req_tready);
      predicted = filter_scan(s);
      pending_results.push_back(pinned ? want : predicted);
      burst_left--;
   endtask

   task automatic randomize_config();
      logic [11:0] low;
      logic [11:0] high;
      wait_drained();
      case ($urandom_range(0, 5))
         0: low = 12'($urandom_range(0, 9));
         1: low = 12'd4095;
         default: low = 12'($urandom_range(10, 1500));
      endcase
      case ($urandom_range(0, 5))
         0: high = 12'd4095;
         1: high = 12'($urandom_range(0, 200));
         default: high = 12'($urandom_range(1500, 4095));
      endcase
      write_reg(REG_FILTER_MODE, 13'($urandom_range(0, 3)));
      write_reg(REG_NOISE_LOW, 13'(low));
      write_reg(REG_NOISE_HIGH, 13'(high));
      case ($urandom_range(0, 5))
         0: write_reg(REG_DETECT_THR, 13'd0);
         1: write_reg(REG_DETECT_THR, 13'd8191);
         default: write_reg(REG_DETECT_THR, 13'($urandom_range(0, 4105)));
      endcase
      for (int ch = 0; ch < 4; ch++) begin
         case ($urandom_range(0, 4))
            0: write_reg(CSR_ADDR_W'(REG_OFFSET_CH0 + ch), 13'd0);
            1: write_reg(CSR_ADDR_W'(REG_OFFSET_CH0 + ch), 13'd255);
            default: write_reg(CSR_ADDR_W'(REG_OFFSET_CH0 + ch),
                               13'($urandom_range(0, 255)));
         endcase
         phase_level[ch] = $urandom_range(0, 4095);
      end
   endtask

   // Result side: stall on a randomly chosen style, picked anew when its run ends.
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_style = rx_style_type'($urandom_range(0, 3));
         rx_left = $urandom_range(16, 160);
      end
      rx_left--;
      case (rx_style)
         RX_OPEN:   rsp_tready <= 1'b1;
         RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
         default:   rsp_tready <= (rx_left % 24) < 6;
      endcase
   end

   task automatic compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      bank_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result beat with no scan outstanding, data %h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            compare_field("front_value", 32'(want.front_value), 32'(rsp_tdata[12:0]));
            compare_field("filtered_1", 32'(want.filtered_1), 32'(rsp_tdata[25:13]));
            compare_field("filtered_2", 32'(want.filtered_2), 32'(rsp_tdata[38:26]));
            compare_field("filtered_3", 32'(want.filtered_3), 32'(rsp_tdata[51:39]));
            compare_field("detect_front", 32'(want.detect_front), 32'(rsp_tdata[52]));
            compare_field("detect_1", 32'(want.detect_1), 32'(rsp_tdata[53]));
            compare_field("detect_2", 32'(want.detect_2), 32'(rsp_tdata[54]));
         end
      end
   end

   initial begin
      scan_type s;
      int    sent;
      int    phase_len;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_we <= 1'b0;
      csr_addr <= '0;
      csr_wdata <= '0;
      load_reset_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_WRITE) begin
            wait_drained();
            write_reg(directed_steps[i].reg_idx, directed_steps[i].reg_val);
         end else begin
            s = {directed_steps[i].s3, directed_steps[i].s2,
                 directed_steps[i].s1, directed_steps[i].s0};
            send_scan(s, directed_steps[i].pinned, directed_steps[i].want);
         end
      end

      sent = 0;
      while (sent < RANDOM_SCANS) begin
         randomize_config();
         phase_len = $urandom_range(40, 120);
         repeat (phase_len) begin
            if ($urandom_range(0, 79) == 0) wait_drained();
            for (int ch = 0; ch < 4; ch++) s[ch] = pick_sample(ch);
            send_scan(s, 1'b0, '0);
         end
         sent += phase_len;
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> distance_sensor_filter_bank_top.f
rtl/core/dsfb_pkg.sv
rtl/core/dsfb_lane.sv
rtl/core/dsfb_merge.sv
rtl/core/distance_sensor_filter_bank_top.sv
dv/testbench.sv
